/* rtl/core/tick_uptime_task_timer_table_defines.svh */
// assertion macros shared by the timer table rtl
// no dependencies; included by files that carry assertions
`ifndef TICK_UPTIME_TASK_TIMER_TABLE_DEFINES_SVH
`define TICK_UPTIME_TASK_TIMER_TABLE_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define TUT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tut: invariant violated");

// condition in one cycle implies a consequence in the next
`define TUT_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("tut: next-cycle check failed");

`endif

/* rtl/core/tut_pkg.sv */
// types, codes and constants of the timer table
// no dependencies; imported by tut_cell and the top level
package tut_pkg;

    localparam int unsigned DEF_TASK_SLOTS   = 8;
    localparam int unsigned MICROS_PER_SEC   = 1000000;
    localparam int unsigned DEF_TICK_US      = 1000;
    localparam logic [15:0] DEF_TICK_LEN     = 16'(DEF_TICK_US);
    localparam logic [15:0] DEF_TICKS_PER_S  = 16'(MICROS_PER_SEC / DEF_TICK_US);
    localparam int unsigned REM_W            = 17;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_FIRED     = 3'd3,
        KIND_UPTIME    = 3'd4,
        KIND_TICK_DONE = 3'd5
    } t_kind;

    typedef enum logic {
        CFG_TICKS_PER_SECOND = 1'b0,
        CFG_TICK_LENGTH_US   = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef enum logic {
        OP_DEC,
        OP_ADD
    } t_cell_op;

    // command broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op    op;
        logic        del;
        logic [2:0]  del_idx;
        logic [15:0] interval;
        logic [15:0] tag;
    } t_cell_cmd;

    // event a cell reports when the token hits it
    typedef struct packed {
        logic        hit;
        logic [15:0] tag;
    } t_cell_ev;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  slot;
        logic [15:0] tag;
        logic [31:0] secs;
        logic [31:0] micros;
        logic        last;
    } t_result;

    function automatic t_result mk_result(t_kind kind, logic [2:0] slot, logic [15:0] tag,
                                          logic [31:0] secs, logic [31:0] micros,
                                          logic last);
        t_result r;
        r.kind   = kind;
        r.slot   = slot;
        r.tag    = tag;
        r.secs   = secs;
        r.micros = micros;
        r.last   = last;
        return r;
    endfunction

endpackage

/* rtl/core/tut_cell.sv */
// one timer slot of the chain: valid mark, remaining seconds, tag
// depends on tut_pkg
module tut_cell import tut_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_tok,
    output logic      o_tok,
    output t_cell_ev  o_ev
);

    logic                    r_valid;
    logic signed [REM_W-1:0] r_rem;
    logic [15:0]             r_tag;
    logic                    r_tok;
    logic                    r_ev_hit;
    logic [15:0]             r_ev_tag;
    logic signed [REM_W-1:0] n_rem;
    logic                    w_del_me;
    logic                    w_fire;
    logic                    w_take;

    assign n_rem    = r_rem - REM_W'(1);
    assign w_del_me = i_cmd.del && (32'(i_cmd.del_idx) == CELL_IDX);
    assign w_fire   = i_tok && (i_cmd.op == OP_DEC) && r_valid && (n_rem <= 0);
    assign w_take   = i_tok && (i_cmd.op == OP_ADD) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_tok    <= 1'b0;
            r_ev_hit <= 1'b0;
        end else begin
            // add stops the token at the first free slot, decrement passes it on
            r_tok    <= i_tok && !w_take;
            r_ev_hit <= w_fire || w_take;
            if (w_del_me || w_fire) begin
                r_valid <= 1'b0;
            end else if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok && (i_cmd.op == OP_DEC) && r_valid) begin
            r_rem <= n_rem;
        end else if (w_take) begin
            r_rem <= REM_W'(i_cmd.interval);
        end
        if (w_take) begin
            r_tag <= i_cmd.tag;
        end
        r_ev_tag <= r_tag;
    end

    assign o_tok     = r_tok;
    assign o_ev.hit  = r_ev_hit;
    assign o_ev.tag  = r_ev_tag;

endmodule

/* rtl/core/tick_uptime_task_timer_table.sv */
// One-shot timer table with an uptime counter.
// Command channel: start with i_mode and its operands is taken when busy is low.
// Modes: tick, add timer, delete timer, read uptime.
// Results come out on o_strobe, one word per cycle, o_last set on the final word
// of a command; the receiver has no backpressure and must take every word.
// A tick that does not finish a second, a delete and an uptime read give
// their word in the cycle after start, with busy staying low.
// A tick that finishes a second sends a token down the chain of TASK_SLOTS
// cells, one cell per cycle; each cell whose timer runs out reports a fired
// word in slot order, then the tick-done word follows.
// An add walks the same chain until the first free cell takes it and gives
// an added word, or a table-full word when no cell is free.
// The chain walk sets the rate: busy stays high while the token is in flight.
// Configuration: i_cfg_valid/o_cfg_ready write port, index 0 ticks per second,
// index 1 tick length in microseconds, both 1000 after reset.
// Reset (synchronous, active low) clears the prescaler, the seconds count
// and all valid marks; timer counts and tags are undefined until added.
// depends on tut_pkg, tut_cell and tick_uptime_task_timer_table_defines.svh
`include "tick_uptime_task_timer_table_defines.svh"

module tick_uptime_task_timer_table import tut_pkg::*; #(
    parameter int unsigned TASK_SLOTS = DEF_TASK_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_interval_seconds,
    input  logic [15:0] i_task_tag,
    input  logic [2:0]  i_slot_index,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_slot,
    output logic [15:0] o_fired_tag,
    output logic [31:0] o_uptime_seconds,
    output logic [31:0] o_uptime_micros,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    t_state      r_state,    n_state;
    logic [15:0] r_tps;
    logic [15:0] r_tlen;
    logic [15:0] r_prescale, n_prescale;
    logic [31:0] r_seconds,  n_seconds;
    logic        r_inj,      n_inj;
    t_cell_cmd   r_cmd,      n_cmd;
    logic        r_strobe,   n_strobe;
    t_result     r_res,      n_res;

    logic [TASK_SLOTS:0]   w_tok;
    t_cell_ev              w_ev [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] w_ev_hits;
    logic                  w_ev_any;
    logic [15:0]           w_ev_tag;
    logic [SLOT_W-1:0]     w_ev_slot;
    logic [15:0]           w_pre_inc;
    logic [31:0]           w_micros;

    // chain of timer cells, token enters at cell 0
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        tut_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_ev    (w_ev[g])
        );
        assign w_ev_hits[g] = w_ev[g].hit;
    end

    // at most one cell reports per cycle, so an or-merge picks it
    always_comb begin
        w_ev_tag  = '0;
        w_ev_slot = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (w_ev[i].hit) begin
                w_ev_tag  = w_ev_tag | w_ev[i].tag;
                w_ev_slot = w_ev_slot | SLOT_W'(i);
            end
        end
    end

    assign w_ev_any  = |w_ev_hits;
    assign w_pre_inc = r_prescale + 16'd1;
    assign w_micros  = 32'(r_tlen) * 32'(r_prescale);

    always_comb begin
        n_state    = r_state;
        n_prescale = r_prescale;
        n_seconds  = r_seconds;
        n_inj      = 1'b0;
        n_cmd      = r_cmd;
        n_cmd.del  = 1'b0;
        n_strobe   = 1'b0;
        n_res      = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_mode'(i_mode))
                        MODE_TICK: begin
                            if (w_pre_inc >= r_tps) begin
                                n_prescale = '0;
                                n_seconds  = r_seconds + 32'd1;
                                n_inj      = 1'b1;
                                n_cmd.op   = OP_DEC;
                                n_state    = ST_WALK;
                            end else begin
                                n_prescale = w_pre_inc;
                                n_strobe   = 1'b1;
                                n_res      = mk_result(KIND_TICK_DONE, '0, '0, '0, '0, 1'b1);
                            end
                        end
                        MODE_ADD: begin
                            n_inj        = 1'b1;
                            n_cmd.op     = OP_ADD;
                            n_cmd.interval = i_interval_seconds;
                            n_cmd.tag    = i_task_tag;
                            n_state      = ST_WALK;
                        end
                        MODE_DEL: begin
                            n_cmd.del     = 1'b1;
                            n_cmd.del_idx = i_slot_index;
                            n_strobe      = 1'b1;
                            n_res = mk_result(KIND_DELETED, i_slot_index, '0, '0, '0, 1'b1);
                        end
                        MODE_READ: begin
                            n_strobe = 1'b1;
                            n_res = mk_result(KIND_UPTIME, '0, '0, r_seconds, w_micros, 1'b1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (w_ev_any) begin
                    n_strobe = 1'b1;
                    if (r_cmd.op == OP_DEC) begin
                        n_res = mk_result(KIND_FIRED, 3'(w_ev_slot), w_ev_tag, '0, '0, 1'b0);
                    end else begin
                        n_res   = mk_result(KIND_ADDED, 3'(w_ev_slot), '0, '0, '0, 1'b1);
                        n_state = ST_IDLE;
                    end
                end
                if (w_tok[TASK_SLOTS]) begin
                    if (r_cmd.op == OP_DEC) begin
                        n_state = ST_DONE;
                    end else begin
                        n_strobe = 1'b1;
                        n_res    = mk_result(KIND_FULL, '0, '0, '0, '0, 1'b1);
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                n_strobe = 1'b1;
                n_res    = mk_result(KIND_TICK_DONE, '0, '0, '0, '0, 1'b1);
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tps      <= DEF_TICKS_PER_S;
            r_tlen     <= DEF_TICK_LEN;
            r_prescale <= '0;
            r_seconds  <= '0;
            r_inj      <= 1'b0;
            r_cmd      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prescale <= n_prescale;
            r_seconds  <= n_seconds;
            r_inj      <= n_inj;
            r_cmd      <= n_cmd;
            r_strobe   <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_TICKS_PER_SECOND: r_tps  <= i_cfg_data;
                    CFG_TICK_LENGTH_US:   r_tlen <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_strobe         = r_strobe;
    assign o_kind           = r_res.kind;
    assign o_slot           = r_res.slot;
    assign o_fired_tag      = r_res.tag;
    assign o_uptime_seconds = r_res.secs;
    assign o_uptime_micros  = r_res.micros;
    assign o_last           = r_res.last;

    `TUT_ASSERT_ALWAYS(a_single_token, i_clk, i_rst_n, $onehot0(w_tok))
    `TUT_ASSERT_ALWAYS(a_single_event, i_clk, i_rst_n, $onehot0(w_ev_hits))
    `TUT_ASSERT_ALWAYS(a_idle_chain_empty, i_clk, i_rst_n, !(r_state == ST_IDLE) || (w_tok == '0))
    `TUT_ASSERT_NEXT(a_start_progress, i_clk, i_rst_n, start && !busy, o_strobe || busy)

endmodule
